/* rtl/kntpc_pkg.sv */
// shared constants, types and helpers for the k-nomial tree peer calculator
package kntpc_pkg;

	localparam int MAX_RANKS = 64;
	localparam int RANK_W    = 6;
	localparam int CNT_W     = 7;
	localparam int DIST_W    = 12;
	localparam int LVL_N     = 6;
	localparam int LVL_W     = 3;

	localparam logic FUNC_FANIN  = 1'b1;
	localparam logic KIND_PARENT = 1'b0;
	localparam logic KIND_CHILD  = 1'b1;

	localparam logic REG_GROUP_SIZE = 1'b0;
	localparam logic REG_TREE_RADIX = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP  = 8'b0000_0010,
		ST_LVL   = 8'b0000_0100,
		ST_DIVW  = 8'b0000_1000,
		ST_PAR   = 8'b0001_0000,
		ST_LOAD  = 8'b0010_0000,
		ST_WALK  = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic              start;
		logic [RANK_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RANK_W-1:0] quo;
		logic [RANK_W-1:0] rem;
	} div_rsp_t;

	// virtual rank back to real rank, both operands below n
	function automatic logic [RANK_W-1:0] mod_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		logic [CNT_W:0] t;
		s = {1'b0, a} + {1'b0, b};
		t = (s >= {1'b0, n}) ? (s - {1'b0, n}) : s;
		return t[RANK_W-1:0];
	endfunction

endpackage

/* rtl/kntpc_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module kntpc_div import kntpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [RANK_W-1:0] num_q;
	logic [RANK_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [LVL_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, num_q[RANK_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LVL_W'(RANK_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[RANK_W-2:0], 1'b0};
			quo_q <= {quo_q[RANK_W-2:0], ge};
			rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[RANK_W-1:0];

endmodule

/* rtl/knomial_tree_peer_calc_core.sv */
// k-nomial tree peer calculator: register port, sequencer and result output
// error and one-rank requests strobe straight out of ST_PREP; otherwise the
// parent strobes from ST_PAR after an ST_LVL/ST_DIVW pass per tree level through the divider;
// children then follow one per cycle within a level, with ST_LOAD and an end ST_WALK per level
// and ST_FLUSH for the last; one request is taken at a time and busy is high meanwhile
// reset: asynchronous, group_size and tree_radix return to 2; results cannot be stalled
module knomial_tree_peer_calc_core import kntpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [RANK_W-1:0] root_rank,
	input  logic [RANK_W-1:0] own_rank,
	output logic              valid,
	output logic              entry_kind,
	output logic              peer_valid,
	output logic [RANK_W-1:0] peer_rank,
	output logic [RANK_W-1:0] child_index,
	output logic              last,
	output logic              bad_request,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CNT_W-1:0]  gsize_q;
	logic [CNT_W-1:0]  radix_q;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  r_eff;

	state_t            state_q;
	logic              func_q;
	logic [RANK_W-1:0] root_q;
	logic [RANK_W-1:0] rank_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  r_q;
	logic [RANK_W-1:0] vrank_q;
	logic [DIST_W-1:0] dist_q;
	logic [RANK_W-1:0] q_q;
	logic [LVL_W-1:0]  nl_q;
	logic [RANK_W-1:0] pv_q;
	logic              hasp_q;
	logic [RANK_W-1:0] lvl_q [LVL_N];
	logic [LVL_W-1:0]  lv_q;
	logic [RANK_W-1:0] dc_q;
	logic [CNT_W-1:0]  vp_q;
	logic [CNT_W-1:0]  i_q;
	logic [RANK_W-1:0] kidx_q;
	logic [RANK_W-1:0] pend_q;
	logic [RANK_W-1:0] pendi_q;

	logic              valid_q;
	logic              kind_q;
	logic              pvld_q;
	logic [RANK_W-1:0] peer_q;
	logic [RANK_W-1:0] idx_q;
	logic              last_q;
	logic              bad_q;

	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              wr_en;
	logic              has_kids;
	logic              lv_final;
	logic [DIST_W-1:0] prod;

	kntpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// effective group size and radix
	always_comb begin
		n_eff = (gsize_q > CNT_W'(MAX_RANKS)) ? CNT_W'(MAX_RANKS) : gsize_q;
		r_eff = (radix_q < CNT_W'(2)) ? CNT_W'(2) : radix_q;
		if (r_eff > n_eff) begin
			r_eff = n_eff;
		end
	end

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TREE_RADIX) ? {25'd0, radix_q} : {25'd0, gsize_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= CNT_W'(2);
			radix_q <= CNT_W'(2);
		end else if (wr_en) begin
			if (paddr[2] == REG_TREE_RADIX) begin
				radix_q <= pwdata[CNT_W-1:0];
			end else begin
				gsize_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign has_kids = (nl_q != '0) && ({1'b0, vrank_q} + 1'b1 < n_q);
	assign lv_final = (func_q == FUNC_FANIN) ? (lv_q == nl_q - 1'b1) : (lv_q == '0);
	assign prod     = DIST_W'(drsp.rem) * dist_q;

	assign dreq.start    = (state_q == ST_LVL) && (dist_q < DIST_W'(n_q));
	assign dreq.dividend = q_q;
	assign dreq.divisor  = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if ({1'b0, root_q} >= n_q || {1'b0, rank_q} >= n_q || n_q == CNT_W'(1)) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					state_q <= (dist_q < DIST_W'(n_q)) ? ST_DIVW : ST_PAR;
				end
				ST_DIVW: begin
					if (drsp.done) begin
						state_q <= (drsp.rem != '0) ? ST_PAR : ST_LVL;
					end
				end
				ST_PAR: begin
					valid_q <= 1'b1;
					state_q <= has_kids ? ST_LOAD : ST_IDLE;
				end
				ST_LOAD: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (i_q < r_q && vp_q < n_q) begin
						valid_q <= (kidx_q != '0);
					end else begin
						state_q <= lv_final ? ST_FLUSH : ST_LOAD;
					end
				end
				ST_FLUSH: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q <= func;
				root_q <= root_rank;
				rank_q <= own_rank;
				n_q    <= n_eff;
				r_q    <= r_eff;
			end
			ST_PREP: begin
				kind_q <= KIND_PARENT;
				pvld_q <= 1'b0;
				peer_q <= '0;
				idx_q  <= '0;
				last_q <= 1'b1;
				bad_q  <= ({1'b0, root_q} >= n_q || {1'b0, rank_q} >= n_q);
				vrank_q <= (rank_q >= root_q) ? (rank_q - root_q)
					: RANK_W'(CNT_W'(rank_q) + n_q - CNT_W'(root_q));
				q_q    <= (rank_q >= root_q) ? (rank_q - root_q)
					: RANK_W'(CNT_W'(rank_q) + n_q - CNT_W'(root_q));
				dist_q <= DIST_W'(1);
				nl_q   <= '0;
				hasp_q <= 1'b0;
			end
			ST_LVL: begin
			end
			ST_DIVW: begin
				if (drsp.done) begin
					if (drsp.rem != '0) begin
						pv_q   <= vrank_q - prod[RANK_W-1:0];
						hasp_q <= 1'b1;
					end else begin
						lvl_q[nl_q] <= dist_q[RANK_W-1:0];
						nl_q        <= nl_q + 1'b1;
						q_q         <= drsp.quo;
						dist_q      <= DIST_W'(dist_q * DIST_W'(r_q));
					end
				end
			end
			ST_PAR: begin
				kind_q <= KIND_PARENT;
				pvld_q <= hasp_q;
				peer_q <= hasp_q ? mod_add(CNT_W'(pv_q), CNT_W'(root_q), n_q) : '0;
				idx_q  <= '0;
				last_q <= !has_kids;
				bad_q  <= 1'b0;
				lv_q   <= (func_q == FUNC_FANIN) ? '0 : nl_q - 1'b1;
				kidx_q <= '0;
			end
			ST_LOAD: begin
				dc_q <= lvl_q[lv_q];
				vp_q <= CNT_W'(vrank_q) + CNT_W'(lvl_q[lv_q]);
				i_q  <= CNT_W'(1);
			end
			ST_WALK: begin
				if (i_q < r_q && vp_q < n_q) begin
					// the previous child goes out now that another one follows
					kind_q  <= KIND_CHILD;
					pvld_q  <= 1'b1;
					peer_q  <= pend_q;
					idx_q   <= pendi_q;
					last_q  <= 1'b0;
					bad_q   <= 1'b0;
					pend_q  <= mod_add(vp_q, CNT_W'(root_q), n_q);
					pendi_q <= kidx_q;
					kidx_q  <= kidx_q + 1'b1;
					i_q     <= i_q + 1'b1;
					vp_q    <= vp_q + CNT_W'(dc_q);
				end else begin
					lv_q <= (func_q == FUNC_FANIN) ? lv_q + 1'b1 : lv_q - 1'b1;
				end
			end
			ST_FLUSH: begin
				kind_q <= KIND_CHILD;
				pvld_q <= 1'b1;
				peer_q <= pend_q;
				idx_q  <= pendi_q;
				last_q <= 1'b1;
				bad_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign valid       = valid_q;
	assign entry_kind  = kind_q;
	assign peer_valid  = pvld_q;
	assign peer_rank   = peer_q;
	assign child_index = idx_q;
	assign last        = last_q;
	assign bad_request = bad_q;

endmodule
